[hw/rtl/nos_pkg.sv]
package nos_pkg;

	localparam int MAX_BEAMS     = 1024;
	localparam int LINEAR_LIMIT  = 1000;
	localparam int ANGULAR_LIMIT = 1000000;

	localparam int RANGE_W = 16;
	localparam int IDX_W   = 10;
	localparam int ANGLE_W = 23;
	localparam int STEP_W  = 17;
	localparam int GAIN_W  = 16;
	localparam int CMD_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int CNT_LIMIT = (MAX_BEAMS - 1 > 1023) ? 1023 : MAX_BEAMS - 1;

	// beam index times angle step, then bearing with sign and offset
	localparam int APROD_W   = IDX_W + STEP_W;
	localparam int BEARING_W = APROD_W + 2;
	localparam int LPROD_W   = GAIN_W + RANGE_W;
	localparam int GPROD_W   = GAIN_W + 1 + BEARING_W;
	localparam int GSHIFT_W  = GPROD_W - 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE        = 3'd0,
		REG_RANGE_FLOOR   = 3'd1,
		REG_RANGE_CEILING = 3'd2,
		REG_START_ANGLE   = 3'd3,
		REG_ANGLE_STEP    = 3'd4,
		REG_GAIN_LINEAR   = 3'd5,
		REG_GAIN_ANGULAR  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                      enable;
		logic [RANGE_W-1:0]        range_floor;
		logic [RANGE_W-1:0]        range_ceiling;
		logic signed [ANGLE_W-1:0] start_angle;
		logic [STEP_W-1:0]         angle_step;
		logic [GAIN_W-1:0]         gain_linear;
		logic [GAIN_W-1:0]         gain_angular;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic mul_idx;
		logic bearing;
		logic scale;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

[hw/rtl/nearest_obstacle_steering.sv]
// Steers towards the nearest obstacle of a laser scan: beams stream in one per cycle with a
// final-beam mark, the block tracks the smallest range and its first beam index, and at the end
// of each scan (while enable is set) it issues a linear speed from the clamped distance and a
// turn rate from the negated beam bearing, both scaled by Q8.8 gains and clamped. Ordinary beams
// are taken at one per cycle; a final beam with enable set holds off further beams while the
// multiplier steps run (index times step, bearing, gain scaling, clamp into the output register),
// and longer only while the previous result still waits to be transferred. Configuration writes
// are always ready and take effect at once, except that a new range ceiling applies from the next
// scan.
module nearest_obstacle_steering (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nos_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nos_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              beam_valid,
	output logic                              beam_stall,
	input  logic [nos_pkg::RANGE_W-1:0]       range_sample,
	input  logic                              last_beam,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [nos_pkg::RANGE_W-1:0]       linear_cmd,
	output logic signed [nos_pkg::CMD_W-1:0]  angular_cmd,
	output logic [nos_pkg::RANGE_W-1:0]       nearest_range,
	output logic [nos_pkg::IDX_W-1:0]         nearest_beam
);
	import nos_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	nos_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nos_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.beam_valid (beam_valid),
		.last_beam  (last_beam),
		.enable     (cfg.enable),
		.status     (status),
		.cmd        (cmd),
		.busy       (beam_stall)
	);

	nos_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.range_sample  (range_sample),
		.last_beam     (last_beam),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.linear_cmd    (linear_cmd),
		.angular_cmd   (angular_cmd),
		.nearest_range (nearest_range),
		.nearest_beam  (nearest_beam)
	);

endmodule

[hw/rtl/nos_cfg.sv]
module nos_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nos_pkg::CFG_DATA_W-1:0] cfg_data,
	output nos_pkg::cfg_t                 cfg
);
	import nos_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b0;
			cfg_q.range_floor   <= '0;
			cfg_q.range_ceiling <= '1;
			cfg_q.start_angle   <= '0;
			cfg_q.angle_step    <= '0;
			cfg_q.gain_linear   <= '0;
			cfg_q.gain_angular  <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:        cfg_q.enable        <= cfg_data[0];
				REG_RANGE_FLOOR:   cfg_q.range_floor   <= cfg_data[RANGE_W-1:0];
				REG_RANGE_CEILING: cfg_q.range_ceiling <= cfg_data[RANGE_W-1:0];
				REG_START_ANGLE:   cfg_q.start_angle   <= $signed(cfg_data[ANGLE_W-1:0]);
				REG_ANGLE_STEP:    cfg_q.angle_step    <= cfg_data[STEP_W-1:0];
				REG_GAIN_LINEAR:   cfg_q.gain_linear   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_ANGULAR:  cfg_q.gain_angular  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/nos_ctrl.sv]
module nos_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beam_valid,
	input  logic             last_beam,
	input  logic             enable,
	input  nos_pkg::status_t status,
	output nos_pkg::cmd_t    cmd,
	output logic             busy
);
	import nos_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_IDX,
		ST_BEARING,
		ST_SCALE,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign busy         = (state_q != ST_IDLE);
	assign cmd.accept   = (state_q == ST_IDLE) && beam_valid;
	assign cmd.mul_idx  = (state_q == ST_MUL_IDX);
	assign cmd.bearing  = (state_q == ST_BEARING);
	assign cmd.scale    = (state_q == ST_SCALE);
	assign cmd.load_out = (state_q == ST_EMIT) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// a final beam starts the command calculation only while running
					if (beam_valid && last_beam && enable)
						state_q <= ST_MUL_IDX;
				end
				ST_MUL_IDX: state_q <= ST_BEARING;
				ST_BEARING: state_q <= ST_SCALE;
				ST_SCALE:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/nos_dp.sv]
module nos_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nos_pkg::cfg_t                    cfg,
	input  nos_pkg::cmd_t                    cmd,
	output nos_pkg::status_t                 status,
	input  logic [nos_pkg::RANGE_W-1:0]      range_sample,
	input  logic                             last_beam,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [nos_pkg::RANGE_W-1:0]      linear_cmd,
	output logic signed [nos_pkg::CMD_W-1:0] angular_cmd,
	output logic [nos_pkg::RANGE_W-1:0]      nearest_range,
	output logic [nos_pkg::IDX_W-1:0]        nearest_beam
);
	import nos_pkg::*;

	localparam logic signed [GSHIFT_W-1:0] ANG_HI = GSHIFT_W'(ANGULAR_LIMIT);
	localparam logic signed [GSHIFT_W-1:0] ANG_LO = -(GSHIFT_W'(64'sd1 <<< 31));
	localparam logic [LPROD_W-9:0]         LIN_HI = (LPROD_W-8)'(LINEAR_LIMIT);

	logic [RANGE_W-1:0]          running_min_q;
	logic [IDX_W-1:0]            min_index_q;
	logic [IDX_W-1:0]            beam_cnt_q;
	logic [RANGE_W-1:0]          dist_q;
	logic [IDX_W-1:0]            idx_q;
	logic [APROD_W-1:0]          angle_prod_q;
	logic signed [BEARING_W-1:0] bearing_q;
	logic [LPROD_W-1:0]          lin_prod_q;
	logic signed [GPROD_W-1:0]   ang_prod_q;
	logic                        out_valid_q;
	logic [RANGE_W-1:0]          linear_q;
	logic signed [CMD_W-1:0]     angular_q;
	logic [RANGE_W-1:0]          nearest_range_q;
	logic [IDX_W-1:0]            nearest_beam_q;

	logic [RANGE_W-1:0]          cur_min;
	logic [IDX_W-1:0]            cur_idx;
	logic [RANGE_W-1:0]          new_min;
	logic [IDX_W-1:0]            new_idx;
	logic signed [BEARING_W-1:0] bearing_sum;
	logic signed [GSHIFT_W-1:0]  ang_floor;
	logic [LPROD_W-9:0]          lin_floor;
	logic [RANGE_W-1:0]          lin_clamped;
	logic signed [CMD_W-1:0]     ang_clamped;

	// the first beam of a scan compares against the ceiling
	always_comb begin
		cur_min = (beam_cnt_q == '0) ? cfg.range_ceiling : running_min_q;
		cur_idx = (beam_cnt_q == '0) ? '0 : min_index_q;
		if (range_sample < cur_min) begin
			new_min = range_sample;
			new_idx = beam_cnt_q;
		end else begin
			new_min = cur_min;
			new_idx = cur_idx;
		end
	end

	assign bearing_sum = $signed({2'b00, angle_prod_q})
		+ BEARING_W'(cfg.start_angle);

	// arithmetic shift gives the floor division by 256
	assign ang_floor = GSHIFT_W'(ang_prod_q >>> 8);
	assign lin_floor = lin_prod_q[LPROD_W-1:8];

	always_comb begin
		if (lin_floor > LIN_HI)
			lin_clamped = RANGE_W'(LINEAR_LIMIT);
		else
			lin_clamped = lin_floor[RANGE_W-1:0];
		priority if (ang_floor > ANG_HI)
			ang_clamped = CMD_W'(ANGULAR_LIMIT);
		else if (ang_floor < ANG_LO)
			ang_clamped = ANG_LO[CMD_W-1:0];
		else
			ang_clamped = ang_floor[CMD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= '1;
			min_index_q   <= '0;
			beam_cnt_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				running_min_q <= new_min;
				min_index_q   <= new_idx;
				if (last_beam)
					beam_cnt_q <= '0;
				else if (beam_cnt_q < IDX_W'(CNT_LIMIT))
					beam_cnt_q <= beam_cnt_q + IDX_W'(1);
			end
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && last_beam) begin
			dist_q <= (new_min < cfg.range_floor) ? cfg.range_floor : new_min;
			idx_q  <= new_idx;
		end
		if (cmd.mul_idx)
			angle_prod_q <= APROD_W'(idx_q) * APROD_W'(cfg.angle_step);
		if (cmd.bearing)
			bearing_q <= -bearing_sum;
		if (cmd.scale) begin
			lin_prod_q <= LPROD_W'(cfg.gain_linear) * LPROD_W'(dist_q);
			ang_prod_q <= GPROD_W'($signed({1'b0, cfg.gain_angular})) * GPROD_W'(bearing_q);
		end
		if (cmd.load_out) begin
			linear_q        <= lin_clamped;
			angular_q       <= ang_clamped;
			nearest_range_q <= dist_q;
			nearest_beam_q  <= idx_q;
		end
	end

	assign status.out_free = !out_valid_q || !result_stall;
	assign result_valid    = out_valid_q;
	assign linear_cmd      = linear_q;
	assign angular_cmd     = angular_q;
	assign nearest_range   = nearest_range_q;
	assign nearest_beam    = nearest_beam_q;

endmodule

[tb/nearest_obstacle_steering_tb.sv]
module nearest_obstacle_steering_tb;
	import nos_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 12;
	localparam int BACKLOG_LEN   = 400;
	localparam int PHASES        = 14;
	localparam int PHASE_BEAMS   = 47;
	localparam int LONG_PHASE    = 6;
	localparam int BACKLOG_PHASE = 2;
	localparam int CALM_PHASE    = 8;
	localparam int OFF_PHASE     = 4;
	localparam int IDLE_PCT      = 21;
	localparam longint ANG_LOW   = -(longint'(1) <<< 31);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [RANGE_W-1:0] sample;
		logic               fin;
	} beam_t;

	typedef struct packed {
		logic [RANGE_W-1:0]      linear;
		logic signed [CMD_W-1:0] angular;
		logic [RANGE_W-1:0]      range;
		logic [IDX_W-1:0]        beam;
	} steer_t;

	typedef enum {SHAPE_TIES, SHAPE_FLOOR, SHAPE_CEILING, SHAPE_WIDE} shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic beam_valid = 1'b0;
	logic beam_stall;
	logic [RANGE_W-1:0] range_sample = '0;
	logic last_beam = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [RANGE_W-1:0] linear_cmd;
	logic signed [CMD_W-1:0] angular_cmd;
	logic [RANGE_W-1:0] nearest_range;
	logic [IDX_W-1:0] nearest_beam;

	// register shadow
	logic                      cfg_enable = 1'b0;
	logic [RANGE_W-1:0]        cfg_floor = '0;
	logic [RANGE_W-1:0]        cfg_ceiling = '1;
	logic signed [ANGLE_W-1:0] cfg_start = '0;
	logic [STEP_W-1:0]         cfg_step = '0;
	logic [GAIN_W-1:0]         cfg_gain_lin = '0;
	logic [GAIN_W-1:0]         cfg_gain_ang = '0;

	// scan tracking state of the predictor
	logic [RANGE_W-1:0] scan_min = '1;
	logic [IDX_W-1:0]   scan_min_idx = '0;
	logic [IDX_W-1:0]   scan_beams = '0;

	beam_t  pending_beams[$];
	steer_t due_steers[$];
	int     fail_count = 0;
	bit     calm = 1'b0;
	bit     backlog_arm = 1'b0;
	bit     backlog_done = 1'b0;
	int     backlog_left = 0;

	nearest_obstacle_steering u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.beam_valid    (beam_valid),
		.beam_stall    (beam_stall),
		.range_sample  (range_sample),
		.last_beam     (last_beam),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.linear_cmd    (linear_cmd),
		.angular_cmd   (angular_cmd),
		.nearest_range (nearest_range),
		.nearest_beam  (nearest_beam)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	function automatic void track_beam(input logic [RANGE_W-1:0] sample, input logic fin);
		logic [RANGE_W-1:0] cur_min;
		logic [IDX_W-1:0]   cur_idx;
		logic [RANGE_W-1:0] clamped;
		longint lin, bearing, ang, g, d, li, st, sa;
		steer_t s;
		cur_min = (scan_beams == 0) ? cfg_ceiling : scan_min;
		cur_idx = (scan_beams == 0) ? '0 : scan_min_idx;
		if (sample < cur_min) begin
			cur_min = sample;
			cur_idx = scan_beams;
		end
		scan_min = cur_min;
		scan_min_idx = cur_idx;
		if (scan_beams < CNT_LIMIT)
			scan_beams++;
		if (!fin)
			return;
		clamped = (cur_min < cfg_floor) ? cfg_floor : cur_min;
		if (cfg_enable) begin
			g = longint'(cfg_gain_lin);
			d = longint'(clamped);
			lin = (g * d) >> 8;
			if (lin > LINEAR_LIMIT)
				lin = longint'(LINEAR_LIMIT);
			li = longint'(cur_idx);
			st = longint'(cfg_step);
			sa = longint'(cfg_start);
			bearing = -(li * st + sa);
			g = longint'(cfg_gain_ang);
			// arithmetic shift rounds towards minus infinity
			ang = (g * bearing) >>> 8;
			if (ang > ANGULAR_LIMIT)
				ang = longint'(ANGULAR_LIMIT);
			if (ang < ANG_LOW)
				ang = ANG_LOW;
			s.linear = lin[RANGE_W-1:0];
			s.angular = ang[CMD_W-1:0];
			s.range = clamped;
			s.beam = cur_idx;
			due_steers.push_back(s);
		end
		scan_min = cfg_ceiling;
		scan_min_idx = '0;
		scan_beams = '0;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < 10)
			$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_result();
		steer_t want;
		if (due_steers.size() == 0) begin
			report_mismatch("result with nothing outstanding");
			return;
		end
		want = due_steers.pop_front();
		if (linear_cmd !== want.linear)
			report_mismatch($sformatf("linear_cmd exp %0d got %0d", want.linear, linear_cmd));
		if (angular_cmd !== want.angular)
			report_mismatch($sformatf("angular_cmd exp %0d got %0d", want.angular,
				angular_cmd));
		if (nearest_range !== want.range)
			report_mismatch($sformatf("nearest_range exp %0d got %0d", want.range,
				nearest_range));
		if (nearest_beam !== want.beam)
			report_mismatch($sformatf("nearest_beam exp %0d got %0d", want.beam, nearest_beam));
	endtask

	// beam sender: hold the payload while stalled, otherwise idle at random outside the calm phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_valid <= 1'b0;
			range_sample <= '0;
			last_beam <= 1'b0;
		end else begin
			if (beam_valid && !beam_stall)
				track_beam(range_sample, last_beam);
			if (!beam_valid || !beam_stall) begin
				if (pending_beams.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					beam_valid <= 1'b1;
					range_sample <= pending_beams[0].sample;
					last_beam <= pending_beams[0].fin;
					pending_beams.delete(0);
				end else begin
					beam_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlog_left <= 0;
			backlog_done <= 1'b0;
		end else if (backlog_arm && !backlog_done) begin
			backlog_left <= BACKLOG_LEN;
			backlog_done <= 1'b1;
		end else if (backlog_left != 0) begin
			backlog_left <= backlog_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			result_stall <= (backlog_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE:        cfg_enable = val[0];
			REG_RANGE_FLOOR:   cfg_floor = val[RANGE_W-1:0];
			REG_RANGE_CEILING: cfg_ceiling = val[RANGE_W-1:0];
			REG_START_ANGLE:   cfg_start = val[ANGLE_W-1:0];
			REG_ANGLE_STEP:    cfg_step = val[STEP_W-1:0];
			REG_GAIN_LINEAR:   cfg_gain_lin = val[GAIN_W-1:0];
			REG_GAIN_ANGULAR:  cfg_gain_ang = val[GAIN_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (pending_beams.size() != 0 || beam_valid || due_steers.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void add_beam(input logic [RANGE_W-1:0] sample, input logic fin);
		beam_t b;
		b.sample = sample;
		b.fin = fin;
		pending_beams.push_back(b);
	endfunction

	function automatic logic [RANGE_W-1:0] clip16(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return v[RANGE_W-1:0];
	endfunction

	function automatic logic [RANGE_W-1:0] draw_range(input shape_t shape);
		case (shape)
			SHAPE_TIES:    return RANGE_W'($urandom_range(0, 3));
			SHAPE_FLOOR:   return clip16(int'(cfg_floor) + int'($urandom_range(0, 40)) - 20);
			SHAPE_CEILING: return clip16(int'(cfg_ceiling) + int'($urandom_range(0, 40)) - 20);
			default:       return RANGE_W'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] draw_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	task automatic randomise_regs(input logic on);
		logic [RANGE_W-1:0] floor_v, ceil_v;
		logic signed [ANGLE_W-1:0] start_v;
		logic [STEP_W-1:0] step_v;
		case ($urandom_range(0, 9))
			0: floor_v = '0;
			1: floor_v = '1;
			default: floor_v = RANGE_W'($urandom_range(0, 3000));
		endcase
		case ($urandom_range(0, 9))
			0: ceil_v = '0;
			1: ceil_v = '1;
			default: ceil_v = RANGE_W'($urandom_range(1000, 65535));
		endcase
		case ($urandom_range(0, 5))
			0: start_v = ANGLE_W'(-3141593);
			1: start_v = ANGLE_W'(3141593);
			2: start_v = {1'b1, {(ANGLE_W-1){1'b0}}};
			3: start_v = {1'b0, {(ANGLE_W-1){1'b1}}};
			default: start_v = ANGLE_W'(int'($urandom_range(0, 6283186)) - 3141593);
		endcase
		case ($urandom_range(0, 5))
			0: step_v = '0;
			1: step_v = STEP_W'(100000);
			2: step_v = '1;
			default: step_v = STEP_W'($urandom_range(0, 100000));
		endcase
		write_reg(REG_ENABLE, CFG_DATA_W'(on));
		write_reg(REG_RANGE_FLOOR, CFG_DATA_W'(floor_v));
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(ceil_v));
		write_reg(REG_START_ANGLE, start_v);
		write_reg(REG_ANGLE_STEP, CFG_DATA_W'(step_v));
		write_reg(REG_GAIN_LINEAR, CFG_DATA_W'(draw_gain()));
		write_reg(REG_GAIN_ANGULAR, CFG_DATA_W'(draw_gain()));
	endtask

	initial begin
		#(CLK_PERIOD * 400000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int phase_beams, len, long_len;
		shape_t shape;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: disabled, scans pass without results
		add_beam(16'd10, 1'b0);
		add_beam(16'd20, 1'b1);
		drain();

		write_reg(REG_ENABLE, CFG_DATA_W'(1'b1));
		write_reg(REG_RANGE_FLOOR, CFG_DATA_W'(16'd0));
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_START_ANGLE, '0);
		write_reg(REG_ANGLE_STEP, CFG_DATA_W'(17'd1000));
		write_reg(REG_GAIN_LINEAR, CFG_DATA_W'(16'd256));
		write_reg(REG_GAIN_ANGULAR, CFG_DATA_W'(16'd256));
		write_reg(REG_UNUSED, '1);
		@(negedge clk);
		add_beam(16'd0, 1'b1);
		add_beam(16'hFFFF, 1'b1);
		// tie: first of the equal minima wins
		add_beam(16'd500, 1'b0);
		add_beam(16'd300, 1'b0);
		add_beam(16'd300, 1'b0);
		add_beam(16'd700, 1'b1);
		add_beam(16'hFFFF, 1'b0);
		add_beam(16'hFFFE, 1'b1);
		drain();

		// floor above ceiling, full gains, far angles
		write_reg(REG_RANGE_FLOOR, CFG_DATA_W'(16'd2000));
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(16'd1500));
		write_reg(REG_START_ANGLE, CFG_DATA_W'(-3141593));
		write_reg(REG_ANGLE_STEP, CFG_DATA_W'(17'd100000));
		write_reg(REG_GAIN_LINEAR, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_GAIN_ANGULAR, CFG_DATA_W'(16'hFFFF));
		@(negedge clk);
		add_beam(16'd3000, 1'b0);
		add_beam(16'd1000, 1'b0);
		add_beam(16'd1200, 1'b1);
		add_beam(16'd1600, 1'b0);
		add_beam(16'd1700, 1'b1);
		drain();

		// zero ceiling: nothing is strictly smaller
		write_reg(REG_RANGE_FLOOR, CFG_DATA_W'(16'd0));
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(16'd0));
		write_reg(REG_START_ANGLE, CFG_DATA_W'(3141593));
		write_reg(REG_ANGLE_STEP, '0);
		@(negedge clk);
		add_beam(16'd0, 1'b0);
		add_beam(16'd5, 1'b1);
		drain();

		// ceiling change in mid scan applies from the next scan
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(16'hFFFF));
		@(negedge clk);
		add_beam(16'd800, 1'b0);
		add_beam(16'd900, 1'b0);
		drain();
		write_reg(REG_RANGE_CEILING, CFG_DATA_W'(16'd500));
		@(negedge clk);
		add_beam(16'd700, 1'b1);
		add_beam(16'd600, 1'b1);
		drain();

		write_reg(REG_ENABLE, CFG_DATA_W'(1'b0));
		@(negedge clk);
		add_beam(16'd10, 1'b0);
		add_beam(16'd20, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			randomise_regs(ph != OFF_PHASE);
			@(negedge clk);
			calm = (ph == CALM_PHASE);
			if (ph == BACKLOG_PHASE)
				backlog_arm = 1'b1;
			if (ph == LONG_PHASE) begin
				// minimum lands at beam 1000 or later, around where the index saturates at 1023
				long_len = $urandom_range(1030, 1100);
				for (int i = 0; i < long_len; i++)
					add_beam((i < 1000) ? RANGE_W'($urandom_range(30000, 65535))
						: RANGE_W'($urandom_range(0, 29999)), i == long_len - 1);
			end
			phase_beams = 0;
			while (phase_beams < PHASE_BEAMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				shape = shape_t'($urandom_range(0, 3));
				for (int i = 0; i < len; i++)
					add_beam(draw_range(shape), i == len - 1);
				phase_beams += len;
			end
			drain();
			calm = 1'b0;
		end

		if (fail_count == 0 && due_steers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[nearest_obstacle_steering.f]
hw/rtl/nos_pkg.sv
hw/rtl/nos_cfg.sv
hw/rtl/nos_ctrl.sv
hw/rtl/nos_dp.sv
hw/rtl/nearest_obstacle_steering.sv
tb/nearest_obstacle_steering_tb.sv
